[rtl/core/mfc_pkg.sv]
// Package for the median-of-three follow-mode controller.
// Holds the widths, register map, mode and phase codes, and the motor command table.
// No dependencies.
package mfc_pkg;

  // Width of a distance sample, of the median and of the distance limits.
  localparam int SAMPLE_WIDTH = 24;
  localparam int COUNT_WIDTH  = 4;
  localparam int DRIVE_WIDTH  = 2;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 4;
  localparam int REG_IDX_W    = 2;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_WIDTH-1:0] FAR_LIMIT_RESET   = SAMPLE_WIDTH'(600000);
  localparam logic [SAMPLE_WIDTH-1:0] NEAR_LIMIT_RESET  = SAMPLE_WIDTH'(250000);
  localparam logic [COUNT_WIDTH-1:0]  COUNT_LIMIT_RESET = COUNT_WIDTH'(10);
  localparam logic [COUNT_WIDTH-1:0]  COUNT_TOP         = '1;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_FAR_LIMIT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_LIMIT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd2;

  // Motor commands in two's complement.
  localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_FWD  = 2'sb01;
  localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_STOP = 2'sb00;
  localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_REV  = 2'sb11;

  typedef enum logic [1:0] {
    MODE_ROTATE = 2'd0,
    MODE_GO     = 2'd1,
    MODE_BACK   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2
  } phase_t;

  // Configuration register contents.
  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] far_limit;
    logic [SAMPLE_WIDTH-1:0] near_limit;
    logic [COUNT_WIDTH-1:0]  count_limit;
  } cfg_t;

  // Outcome of one decision.
  typedef struct packed {
    mode_t                   mode;
    logic [COUNT_WIDTH-1:0]  far_count;
    logic [SAMPLE_WIDTH-1:0] median;
    logic                    changed;
  } decision_t;

  // Left motor command of a mode.
  function automatic logic signed [DRIVE_WIDTH-1:0] left_of_mode(mode_t mode);
    logic signed [DRIVE_WIDTH-1:0] cmd;
    unique case (mode)
      MODE_ROTATE: cmd = DRIVE_STOP;
      MODE_GO:     cmd = DRIVE_FWD;
      MODE_BACK:   cmd = DRIVE_REV;
      default:     cmd = DRIVE_STOP;
    endcase
    return cmd;
  endfunction

  // Right motor command of a mode.
  function automatic logic signed [DRIVE_WIDTH-1:0] right_of_mode(mode_t mode);
    logic signed [DRIVE_WIDTH-1:0] cmd;
    unique case (mode)
      MODE_ROTATE: cmd = DRIVE_FWD;
      MODE_GO:     cmd = DRIVE_FWD;
      MODE_BACK:   cmd = DRIVE_REV;
      default:     cmd = DRIVE_STOP;
    endcase
    return cmd;
  endfunction

endpackage

[rtl/core/mfc_apb_regs.sv]
// Configuration registers of the follow-mode controller behind an APB-style port.
// Depends on mfc_pkg for the register map and the cfg_t struct.
module mfc_apb_regs import mfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.far_limit   <= FAR_LIMIT_RESET;
      cfg.near_limit  <= NEAR_LIMIT_RESET;
      cfg.count_limit <= COUNT_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FAR_LIMIT:   cfg.far_limit   <= pwdata[SAMPLE_WIDTH-1:0];
        REG_NEAR_LIMIT:  cfg.near_limit  <= pwdata[SAMPLE_WIDTH-1:0];
        REG_COUNT_LIMIT: cfg.count_limit <= pwdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    unique case (reg_idx)
      REG_FAR_LIMIT:   prdata = APB_DATA_W'(cfg.far_limit);
      REG_NEAR_LIMIT:  prdata = APB_DATA_W'(cfg.near_limit);
      REG_COUNT_LIMIT: prdata = APB_DATA_W'(cfg.count_limit);
      default:         prdata = '0;
    endcase
  end

endmodule

[rtl/core/mfc_decide.sv]
// Median of three and the drive mode rules for one decision.
// Depends on mfc_pkg for the mode codes and the cfg_t and decision_t structs.
module mfc_decide import mfc_pkg::*; (
  input  logic [SAMPLE_WIDTH-1:0] first_sample,
  input  logic [SAMPLE_WIDTH-1:0] second_sample,
  input  logic [SAMPLE_WIDTH-1:0] third_sample,
  input  mode_t                   mode,
  input  logic [COUNT_WIDTH-1:0]  far_count,
  input  cfg_t                    cfg,
  output decision_t               decision
);

  logic [SAMPLE_WIDTH-1:0] lo_ab;
  logic [SAMPLE_WIDTH-1:0] hi_ab;
  logic [SAMPLE_WIDTH-1:0] lo_hi_c;
  logic [SAMPLE_WIDTH-1:0] median;
  logic                    is_far;
  logic                    is_near;
  logic [COUNT_WIDTH-1:0]  count_inc;
  mode_t                   mode_next;
  logic [COUNT_WIDTH-1:0]  count_next;

  // Median as max(min(a, b), min(max(a, b), c)).
  assign lo_ab   = (first_sample < second_sample) ? first_sample : second_sample;
  assign hi_ab   = (first_sample < second_sample) ? second_sample : first_sample;
  assign lo_hi_c = (hi_ab < third_sample) ? hi_ab : third_sample;
  assign median  = (lo_ab > lo_hi_c) ? lo_ab : lo_hi_c;

  assign is_far  = median > cfg.far_limit;
  assign is_near = median <= cfg.near_limit;

  // The far counter saturates at its top value.
  assign count_inc = (far_count < COUNT_TOP) ? far_count + 1'b1 : far_count;

  // Mode rules.
  always_comb begin
    mode_next  = mode;
    count_next = far_count;
    unique case (mode)
      MODE_GO: begin
        if (is_far) begin
          count_next = count_inc;
          if (count_inc >= cfg.count_limit) mode_next = MODE_ROTATE;
        end else if (is_near) begin
          mode_next = MODE_BACK;
        end
      end
      MODE_BACK: begin
        if (is_far) begin
          count_next = count_inc;
          if (count_inc >= cfg.count_limit) mode_next = MODE_ROTATE;
        end else if (!is_near) begin
          mode_next = MODE_GO;
        end
      end
      default: begin
        if (!is_far) begin
          count_next = '0;
          mode_next  = is_near ? MODE_BACK : MODE_GO;
        end
      end
    endcase
  end

  assign decision.mode      = mode_next;
  assign decision.far_count = count_next;
  assign decision.median    = median;
  assign decision.changed   = mode_next != mode;

endmodule

[rtl/core/median3_follow_mode_controller.sv]
// Top level of the median-of-three follow-mode controller.
// Depends on mfc_pkg, mfc_apb_regs and mfc_decide.

// The block accepts one distance sample per clock cycle when not stalled. Samples
// are grouped in fresh threes; every third sample produces one result item,
// which moves from the input register into the output register. The first and
// second samples of a group produce no result. Input and output are parted by
// an input register and the output register, so samples keep flowing while a
// result waits; the input stalls only when a third sample sits in the input
// register and the output register still holds an untaken result. The user
// must write the limits through the APB-style port only while idle (unenforced).
module median3_follow_mode_controller import mfc_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_WIDTH-1:0]        distance_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     drive_mode,
  output logic signed [DRIVE_WIDTH-1:0]  left_drive,
  output logic signed [DRIVE_WIDTH-1:0]  right_drive,
  output logic [SAMPLE_WIDTH-1:0]        median_distance,
  output logic                           mode_changed,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [APB_ADDR_W-1:0]          paddr,
  input  logic [APB_DATA_W-1:0]          pwdata,
  output logic [APB_DATA_W-1:0]          prdata,
  output logic                           pready
);

  cfg_t                    cfg;
  decision_t               decision;

  logic                    in_reg_valid;
  logic [SAMPLE_WIDTH-1:0] in_reg_sample;
  logic                    advance;
  logic                    out_free;

  logic [SAMPLE_WIDTH-1:0] first_sample;
  logic [SAMPLE_WIDTH-1:0] second_sample;
  phase_t                  group_phase;
  phase_t                  group_phase_next;
  mode_t                   current_mode;
  logic [COUNT_WIDTH-1:0]  far_count;

  mfc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfc_decide u_decide (
    .first_sample  (first_sample),
    .second_sample (second_sample),
    .third_sample  (in_reg_sample),
    .mode          (current_mode),
    .far_count     (far_count),
    .cfg           (cfg),
    .decision      (decision)
  );

  // A held item moves on unless it completes a group and the result slot is busy.
  assign out_free = !out_valid || out_ready;
  assign advance  = in_reg_valid && (group_phase != PHASE_THIRD || out_free);
  assign in_ready = !in_reg_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_sample <= distance_sample;
    end
  end

  // Group phase sequencing.
  always_comb begin
    group_phase_next = group_phase;
    if (advance) begin
      unique case (group_phase)
        PHASE_FIRST:  group_phase_next = PHASE_SECOND;
        PHASE_SECOND: group_phase_next = PHASE_THIRD;
        default:      group_phase_next = PHASE_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= PHASE_FIRST;
    end else begin
      group_phase <= group_phase_next;
    end
  end

  // Stored samples of the current group.
  always_ff @(posedge clk) begin
    if (advance && group_phase == PHASE_FIRST) begin
      first_sample <= in_reg_sample;
    end
    if (advance && group_phase == PHASE_SECOND) begin
      second_sample <= in_reg_sample;
    end
  end

  // Mode and far counter update on each decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode <= MODE_ROTATE;
      far_count    <= '0;
    end else if (advance && group_phase == PHASE_THIRD) begin
      current_mode <= decision.mode;
      far_count    <= decision.far_count;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && group_phase == PHASE_THIRD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && group_phase == PHASE_THIRD) begin
      drive_mode      <= decision.mode;
      left_drive      <= left_of_mode(decision.mode);
      right_drive     <= right_of_mode(decision.mode);
      median_distance <= decision.median;
      mode_changed    <= decision.changed;
    end
  end

endmodule
